/* rtl/victim_cache_lru_lookup_insert_macros.svh */
// Assertion macros for the victim cache block.
// No dependencies; included by the files that carry assertions.
`ifndef VICTIM_CACHE_LRU_LOOKUP_INSERT_MACROS_SVH
`define VICTIM_CACHE_LRU_LOOKUP_INSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VCLRU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vclru assertion failed");
`define VCLRU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("vclru assertion failed");
`else
`define VCLRU_ASSERT(lbl, clk, rst, prop)
`define VCLRU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/vclru_pkg.sv */
// Shared types and constants of the victim cache block.
// No dependencies; used by vclru_entries and the top level.
package vclru_pkg;

   localparam int ADDR_BITS   = 25;
   localparam int SLOT_BITS   = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_USER_W  = 1;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_INSERT = 1'b1
   } req_kind_type;

   typedef enum logic {
      POLICY_MRU = 1'b0,
      POLICY_LRU = 1'b1
   } policy_type;

   typedef struct packed {
      logic         fire;
      req_kind_type kind;
      policy_type   policy;
   } step_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
   } result_type;

endpackage

/* rtl/victim_cache_lru_lookup_insert.sv */
// Top level of the fully associative victim cache with recency ages.
// Depends on vclru_pkg, vclru_entries and the assertion macro header.
//
//   channel | direction | tdata                  | tuser
//   req_    | in        | [24:0] phys_addr       | [0] req_type, [1] replace_policy
//   rsp_    | out       | [2:0] slot             | [0] hit
//
// One item per cycle sustained while rsp_tready holds high; an accepted item
// goes into the input register, then in one pass through the entry compare
// and age update into the result register. Cache state updates as the result
// register loads, so the next item sees it. Synchronous reset clears valid
// bits and sets each entry's age to its slot index. A stalled result holds
// the input register, which then drops req_tready until the result moves.
`include "victim_cache_lru_lookup_insert_macros.svh"
module victim_cache_lru_lookup_insert
   import vclru_pkg::*;
#(
   parameter int NUM_ENTRIES = 8,
   parameter int OFFSET_BITS = 5,
   parameter int TAG_BITS    = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [24:0] phys_addr, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,  // [0] req_type, [1] replace_policy
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [2:0] slot, rest zero
   output logic [RSP_USER_W-1:0] rsp_tuser   // [0] hit
);

   logic                 in_valid_ff;
   req_kind_type         in_kind_ff;
   policy_type           in_policy_ff;
   logic [ADDR_BITS-1:0] in_addr_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   logic                 fire;
   step_type             step;
   result_type           result;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign step.fire   = fire;
   assign step.kind   = in_kind_ff;
   assign step.policy = in_policy_ff;

   vclru_entries #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .OFFSET_BITS (OFFSET_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_entries (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .phys_addr (in_addr_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff   <= req_kind_type'(req_tuser[0]);
         in_policy_ff <= policy_type'(req_tuser[1]);
         in_addr_ff   <= req_tdata[ADDR_BITS-1:0];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SLOT_BITS){1'b0}}, rsp_ff.slot};
   assign rsp_tuser  = rsp_ff.hit;

   `VCLRU_ASSERT(a_fire_loads_rsp, clock, reset, fire |=> rsp_tvalid)
   `VCLRU_ASSERT(a_no_fire_when_blocked, clock, reset,
      (rsp_valid_ff && !rsp_tready) |-> !fire)
   `VCLRU_ASSERT(a_held_item_blocks_req, clock, reset,
      (in_valid_ff && !fire) |-> !req_tready)
   `VCLRU_ASSERT(a_hit_only_on_lookup, clock, reset,
      (fire && result.hit) |-> (in_kind_ff == REQ_LOOKUP))

endmodule

/* rtl/vclru_entries.sv */
// Entry array of the victim cache: tags, valid bits, recency ages,
// the parallel match and the age update. Depends on vclru_pkg.
module vclru_entries
   import vclru_pkg::*;
#(
   parameter int NUM_ENTRIES = 8,
   parameter int OFFSET_BITS = 5,
   parameter int TAG_BITS    = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  step_type             step,
   input  logic [ADDR_BITS-1:0] phys_addr,
   output result_type           result
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam logic [IDX_W-1:0] MAX_AGE = IDX_W'(NUM_ENTRIES - 1);

   logic [TAG_BITS-1:0]  tag_ff   [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [IDX_W-1:0]     age_ff   [NUM_ENTRIES];
   logic [IDX_W-1:0]     age_in   [NUM_ENTRIES];

   logic [ADDR_BITS+TAG_BITS-1:0] addr_ext;
   logic [TAG_BITS-1:0]           tag;
   logic [IDX_W-1:0]              want_age;
   logic [NUM_ENTRIES-1:0]        cand;
   logic [NUM_ENTRIES-1:0]        sel_oh;
   logic                          found;
   logic [IDX_W-1:0]              sel_idx;
   logic [IDX_W-1:0]              own_age;
   logic                          touch;
   logic                          write_tag;
   logic [IDX_W+SLOT_BITS-1:0]    slot_ext;

   assign addr_ext = {{TAG_BITS{1'b0}}, phys_addr} >> OFFSET_BITS;
   assign tag      = addr_ext[TAG_BITS-1:0];
   assign want_age = (step.policy == POLICY_MRU) ? MAX_AGE : '0;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (step.kind == REQ_LOOKUP) begin
            cand[i] = valid_ff[i] && (tag_ff[i] == tag);
         end else begin
            cand[i] = (age_ff[i] == want_age);
         end
      end
   end

   // keep only the lowest candidate
   assign sel_oh = cand & (~cand + NUM_ENTRIES'(1));
   assign found  = |cand;

   always_comb begin
      sel_idx = '0;
      own_age = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (sel_oh[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
            own_age = own_age | age_ff[i];
         end
      end
   end

   assign touch     = step.fire && found &&
                      ((step.kind == REQ_LOOKUP) || (step.policy == POLICY_LRU));
   assign write_tag = step.fire && found && (step.kind == REQ_INSERT);

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (touch) begin
            if (sel_oh[i]) begin
               age_in[i] = MAX_AGE;
            end else if (age_ff[i] > own_age) begin
               age_in[i] = age_ff[i] - IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            age_ff[i] <= IDX_W'(i);
         end
      end else begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
            if (write_tag && sel_oh[i]) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   // tags matter only behind a valid bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (write_tag && sel_oh[i]) begin
            tag_ff[i] <= tag;
         end
      end
   end

   assign slot_ext    = {{SLOT_BITS{1'b0}}, (found ? sel_idx : '0)};
   assign result.hit  = found && (step.kind == REQ_LOOKUP);
   assign result.slot = slot_ext[SLOT_BITS-1:0];

endmodule
